// ----- rtl/biquad_escape_time_iterator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the biquad escape-time iterator
// Implication and next-cycle forms with a common reset guard.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_ESCAPE_TIME_ITERATOR_ASSERT_SVH
`define BIQUAD_ESCAPE_TIME_ITERATOR_ASSERT_SVH

// same-cycle implication
`define BETI_ASSERT_IMP(label, c, r, ante, cons, msg) \
	label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BETI_ASSERT_NXT(label, c, r, ante, cons, msg) \
	label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/beti_pkg.sv -----
// ----------------------------------------------------------------------------
// beti_pkg
// Types, micro-op encodings and schedules for the escape-time iterator.
// ----------------------------------------------------------------------------
package beti_pkg;

	localparam int DATA_W    = 32;
	localparam int CNT_OUT_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int PH_W      = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_RE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_IM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_RE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_IM    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd4;

	localparam logic [PH_W-1:0] TEST_ISSUES = 5'd2;
	localparam logic [PH_W-1:0] TEST_LAST   = 5'd3;
	localparam logic [PH_W-1:0] STEP_ISSUES = 5'd16;
	localparam logic [PH_W-1:0] STEP_LAST   = 5'd16;

	typedef enum logic [1:0] {ST_IDLE, ST_TEST, ST_STEP, ST_FIN} beti_state_t;

	typedef enum logic [2:0] {A_XR, A_XI, A_CR, A_CI, A_LR, A_LI, A_WR, A_WI} beti_asel_t;
	typedef enum logic [2:0] {B_XR, B_XI, B_TR, B_YR, B_YI, B_UR1, B_UI} beti_bsel_t;
	typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} beti_accop_t;
	typedef enum logic [3:0] {
		D_NONE, D_XR, D_XI, D_YR, D_YI, D_UR, D_UI, D_WR, D_WI, D_ESC
	} beti_dest_t;

	typedef struct packed {
		beti_asel_t  a;
		beti_bsel_t  b;
		beti_accop_t op;
		beti_dest_t  dest;
	} beti_uop_t;

	typedef struct packed {
		logic      start;
		logic      issue;
		beti_uop_t uop;
	} beti_ctl_t;

	typedef struct packed {
		logic sat;
		logic esc;
	} beti_sts_t;

	// escape test: |x|^2
	function automatic beti_uop_t test_uop(input logic [PH_W-1:0] ph);
		beti_uop_t u;
		case (ph)
			5'd0:    u = '{A_XR, B_XR, ACC_LOAD, D_NONE};
			5'd1:    u = '{A_XI, B_XI, ACC_ADD,  D_ESC};
			default: u = '{A_XR, B_XR, ACC_LOAD, D_NONE};
		endcase
		return u;
	endfunction

	// one map step: y = x(1+x), u = a*y, w = lambda*y, x = w(1+u)
	function automatic beti_uop_t step_uop(input logic [PH_W-1:0] ph);
		beti_uop_t u;
		case (ph)
			5'd0:    u = '{A_XR, B_TR,  ACC_LOAD, D_NONE};
			5'd1:    u = '{A_XI, B_XI,  ACC_SUB,  D_YR};
			5'd2:    u = '{A_XR, B_XI,  ACC_LOAD, D_NONE};
			5'd3:    u = '{A_XI, B_TR,  ACC_ADD,  D_YI};
			5'd4:    u = '{A_CI, B_YR,  ACC_LOAD, D_NONE};
			5'd5:    u = '{A_CR, B_YI,  ACC_ADD,  D_UI};
			5'd6:    u = '{A_CR, B_YR,  ACC_LOAD, D_NONE};
			5'd7:    u = '{A_CI, B_YI,  ACC_SUB,  D_UR};
			5'd8:    u = '{A_LR, B_YR,  ACC_LOAD, D_NONE};
			5'd9:    u = '{A_LI, B_YI,  ACC_SUB,  D_WR};
			5'd10:   u = '{A_LR, B_YI,  ACC_LOAD, D_NONE};
			5'd11:   u = '{A_LI, B_YR,  ACC_ADD,  D_WI};
			5'd12:   u = '{A_WR, B_UR1, ACC_LOAD, D_NONE};
			5'd13:   u = '{A_WI, B_UI,  ACC_SUB,  D_XR};
			5'd14:   u = '{A_WR, B_UI,  ACC_LOAD, D_NONE};
			5'd15:   u = '{A_WI, B_UR1, ACC_ADD,  D_XI};
			default: u = '{A_XR, B_XR,  ACC_LOAD, D_NONE};
		endcase
		return u;
	endfunction

endpackage

// ----- rtl/beti_if.sv -----
// ----------------------------------------------------------------------------
// beti_if
// Valid/ready channels for start points and results.
// ----------------------------------------------------------------------------
interface beti_in_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [31:0] start_re;
	logic signed [31:0] start_im;

	modport source (output valid, opcode, start_re, start_im, input ready);
	modport sink   (input valid, opcode, start_re, start_im, output ready);
endinterface

interface beti_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        iterations;
	logic               bounded;
	logic signed [31:0] next_re;
	logic signed [31:0] next_im;

	modport source (output valid, iterations, bounded, next_re, next_im, input ready);
	modport sink   (input valid, iterations, bounded, next_re, next_im, output ready);
endinterface

// ----- rtl/beti_dp.sv -----
// ----------------------------------------------------------------------------
// beti_dp
// Shared 32x32 multiplier, 65-bit accumulator and complex operand registers.
// ----------------------------------------------------------------------------
module beti_dp import beti_pkg::*; #(
	parameter int FRAC_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  beti_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] start_re,
	input  logic signed [DATA_W-1:0] start_im,
	input  logic signed [DATA_W-1:0] lambda_re,
	input  logic signed [DATA_W-1:0] lambda_im,
	input  logic signed [DATA_W-1:0] coef_re,
	input  logic signed [DATA_W-1:0] coef_im,
	output beti_sts_t                sts,
	output logic signed [DATA_W-1:0] x_re,
	output logic signed [DATA_W-1:0] x_im
);

	localparam logic signed [DATA_W:0] ONE     = 33'sd1 <<< FRAC_BITS;
	localparam logic signed [64:0]     ESC_LIM = 65'sd10 <<< (2 * FRAC_BITS);

	logic signed [DATA_W-1:0] xr_q, xi_q, yr_q, yi_q, ur_q, ui_q, wr_q, wi_q;
	logic signed [DATA_W-1:0] a_op, b_op;
	logic [DATA_W:0]          t_sum, ur1_sum;
	logic signed [63:0]       prod;
	logic signed [63:0]       prod_s1;
	beti_accop_t              op_s1;
	beti_dest_t               dest_s1;
	logic                     vld_s1;
	logic signed [64:0]       acc_q, acc_next, scaled;
	logic                     fits;
	logic signed [DATA_W-1:0] res;
	logic                     sat_q, esc_q;
	logic                     add_sat;

	// {saturated, value} of v + 1.0
	function automatic logic [DATA_W:0] add_one(input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W:0] s;
		s = {v[DATA_W-1], v} + ONE;
		if (s[DATA_W] != s[DATA_W-1])
			return {1'b1, s[DATA_W] ? 32'sh8000_0000 : 32'sh7fff_ffff};
		return {1'b0, s[DATA_W-1:0]};
	endfunction

	assign t_sum   = add_one(xr_q);
	assign ur1_sum = add_one(ur_q);

	always_comb begin
		case (ctl.uop.a)
			A_XR:    a_op = xr_q;
			A_XI:    a_op = xi_q;
			A_CR:    a_op = coef_re;
			A_CI:    a_op = coef_im;
			A_LR:    a_op = lambda_re;
			A_LI:    a_op = lambda_im;
			A_WR:    a_op = wr_q;
			A_WI:    a_op = wi_q;
			default: a_op = xr_q;
		endcase
	end

	always_comb begin
		add_sat = 1'b0;
		case (ctl.uop.b)
			B_XR:  b_op = xr_q;
			B_XI:  b_op = xi_q;
			B_TR: begin
				b_op    = t_sum[DATA_W-1:0];
				add_sat = t_sum[DATA_W];
			end
			B_YR:  b_op = yr_q;
			B_YI:  b_op = yi_q;
			B_UR1: begin
				b_op    = ur1_sum[DATA_W-1:0];
				add_sat = ur1_sum[DATA_W];
			end
			B_UI:    b_op = ui_q;
			default: b_op = xr_q;
		endcase
	end

	assign prod = a_op * b_op;

	always_comb begin
		case (op_s1)
			ACC_LOAD: acc_next = {prod_s1[63], prod_s1};
			ACC_ADD:  acc_next = acc_q + {prod_s1[63], prod_s1};
			ACC_SUB:  acc_next = acc_q - {prod_s1[63], prod_s1};
			default:  acc_next = {prod_s1[63], prod_s1};
		endcase
	end

	assign scaled = acc_next >>> FRAC_BITS;
	assign fits   = (&scaled[64:DATA_W-1]) | ~(|scaled[64:DATA_W-1]);
	assign res    = fits ? scaled[DATA_W-1:0]
	                     : (scaled[64] ? 32'sh8000_0000 : 32'sh7fff_ffff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			sat_q  <= 1'b0;
			esc_q  <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			if (ctl.start) begin
				sat_q <= 1'b0;
				esc_q <= 1'b0;
			end else begin
				if ((ctl.issue && add_sat) ||
				    (vld_s1 && !fits && dest_s1 != D_NONE && dest_s1 != D_ESC))
					sat_q <= 1'b1;
				if (vld_s1 && dest_s1 == D_ESC)
					esc_q <= (acc_next >= ESC_LIM);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		op_s1   <= ctl.uop.op;
		dest_s1 <= ctl.uop.dest;
		if (vld_s1)
			acc_q <= acc_next;
		if (ctl.start) begin
			xr_q <= start_re;
			xi_q <= start_im;
		end else if (vld_s1) begin
			case (dest_s1)
				D_XR:    xr_q <= res;
				D_XI:    xi_q <= res;
				D_YR:    yr_q <= res;
				D_YI:    yi_q <= res;
				D_UR:    ur_q <= res;
				D_UI:    ui_q <= res;
				D_WR:    wr_q <= res;
				D_WI:    wi_q <= res;
				default: ;
			endcase
		end
	end

	assign sts.sat = sat_q;
	assign sts.esc = esc_q;
	assign x_re    = xr_q;
	assign x_im    = xi_q;

endmodule

// ----- rtl/beti_seq.sv -----
// ----------------------------------------------------------------------------
// beti_seq
// Sequencer: escape test, map step, iteration count and finish.
// ----------------------------------------------------------------------------
module beti_seq import beti_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_opcode,
	input  logic [COUNT_BITS-1:0] lim,
	input  beti_sts_t             sts,
	input  logic                  out_free,
	output logic                  in_ready,
	output beti_ctl_t             ctl,
	output logic                  fin,
	output logic                  op_step,
	output logic                  bounded,
	output logic [COUNT_BITS-1:0] count
);

	beti_state_t           state_q, state_d;
	logic [PH_W-1:0]       ph_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  op_q;
	logic                  stop;

	assign stop = (cnt_q >= lim) || sts.sat || sts.esc;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = in_opcode ? ST_STEP : ST_TEST;
			end
			ST_TEST: begin
				if (ph_q == TEST_LAST)
					state_d = stop ? ST_FIN : ST_STEP;
			end
			ST_STEP: begin
				if (ph_q == STEP_LAST)
					state_d = op_q ? ST_FIN : ST_TEST;
			end
			ST_FIN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		fin       = 1'b0;
		ctl.start = 1'b0;
		ctl.issue = 1'b0;
		ctl.uop   = step_uop(ph_q);
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ctl.start = in_valid;
			end
			ST_TEST: begin
				ctl.issue = (ph_q < TEST_ISSUES);
				ctl.uop   = test_uop(ph_q);
			end
			ST_STEP: begin
				ctl.issue = (ph_q < STEP_ISSUES);
			end
			ST_FIN: begin
				fin = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= '0;
			cnt_q   <= '0;
			op_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= (state_d != state_q) ? '0 : ph_q + 1'b1;
			if (state_q == ST_IDLE && in_valid) begin
				cnt_q <= '0;
				op_q  <= in_opcode;
			end else if (state_q == ST_STEP && ph_q == STEP_LAST && !op_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign op_step = op_q;
	assign bounded = !op_q && (cnt_q >= lim);
	assign count   = cnt_q;

endmodule

// ----- rtl/biquad_escape_time_iterator.sv -----
// ----------------------------------------------------------------------------
// biquad_escape_time_iterator
// Escape-time iteration of y = x(1+x), x = lambda*y*(1+a*y) in signed Q8.24.
//
//   channel  dir  payload
//   pixel    in   opcode, start_re, start_im
//   result   out  iterations, bounded, next_re, next_im
//   cfg_*    in   write enable, register index, data
//
// One 32x32 multiplier is shared: 16 products per map step, 2 per escape test.
// A new start point is taken once the previous result sits in the output
// register; a stalled result holds until taken. Reset clears control and
// returns the registers to lambda = 1.0, a = 0, limit = 100.
// ----------------------------------------------------------------------------
`include "biquad_escape_time_iterator_assert.svh"

module biquad_escape_time_iterator import beti_pkg::*; #(
	parameter int FRAC_BITS  = 24,
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	beti_in_if.sink              pixel,
	beti_out_if.source           result
);

	localparam int CAP = (1 << COUNT_BITS) - 1;

	logic signed [DATA_W-1:0] lambda_re_q, lambda_im_q, coef_re_q, coef_im_q;
	logic [CNT_OUT_W-1:0]     iter_limit_q;
	logic [31:0]              lim_w;
	logic [COUNT_BITS-1:0]    lim;
	beti_ctl_t                ctl;
	beti_sts_t                sts;
	logic signed [DATA_W-1:0] x_re, x_im;
	logic                     fin, op_step, bnd, out_free;
	logic [COUNT_BITS-1:0]    count;
	logic [31:0]              count_w;

	logic                     res_valid_q;
	logic [CNT_OUT_W-1:0]     res_iter_q;
	logic                     res_bnd_q;
	logic signed [DATA_W-1:0] res_re_q, res_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_re_q  <= 32'sd1 <<< FRAC_BITS;
			lambda_im_q  <= '0;
			coef_re_q    <= '0;
			coef_im_q    <= '0;
			iter_limit_q <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LAMBDA_RE:  lambda_re_q  <= cfg_data;
				CFG_LAMBDA_IM:  lambda_im_q  <= cfg_data;
				CFG_COEF_RE:    coef_re_q    <= cfg_data;
				CFG_COEF_IM:    coef_im_q    <= cfg_data;
				CFG_ITER_LIMIT: iter_limit_q <= cfg_data[CNT_OUT_W-1:0];
				default: ;
			endcase
		end
	end

	assign lim_w = (32'(iter_limit_q) < 32'(CAP)) ? 32'(iter_limit_q) : 32'(CAP);
	assign lim   = lim_w[COUNT_BITS-1:0];

	assign out_free = !res_valid_q || result.ready;

	beti_seq #(.COUNT_BITS(COUNT_BITS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_opcode (pixel.opcode),
		.lim       (lim),
		.sts       (sts),
		.out_free  (out_free),
		.in_ready  (pixel.ready),
		.ctl       (ctl),
		.fin       (fin),
		.op_step   (op_step),
		.bounded   (bnd),
		.count     (count)
	);

	beti_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.start_re  (pixel.start_re),
		.start_im  (pixel.start_im),
		.lambda_re (lambda_re_q),
		.lambda_im (lambda_im_q),
		.coef_re   (coef_re_q),
		.coef_im   (coef_im_q),
		.sts       (sts),
		.x_re      (x_re),
		.x_im      (x_im)
	);

	assign count_w = 32'(count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (fin)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_iter_q <= (op_step || bnd) ? '0 : count_w[CNT_OUT_W-1:0];
			res_bnd_q  <= bnd;
			res_re_q   <= op_step ? x_re : '0;
			res_im_q   <= op_step ? x_im : '0;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.iterations = res_iter_q;
	assign result.bounded    = res_bnd_q;
	assign result.next_re    = res_re_q;
	assign result.next_im    = res_im_q;

	`BETI_ASSERT_NXT(a_busy_after_accept, clk, arst_n, pixel.valid && pixel.ready,
		!pixel.ready, "input taken while a transaction is in progress")
	`BETI_ASSERT_IMP(a_bounded_zero_count, clk, arst_n, result.valid && result.bounded,
		result.iterations == '0, "bounded result with non-zero count")
	`BETI_ASSERT_IMP(a_point_only_on_step, clk, arst_n,
		result.valid && (result.next_re != '0 || result.next_im != '0),
		!result.bounded && result.iterations == '0, "point returned on iterate transaction")

endmodule
